// File: rtl/wprm_pkg.sv
`timescale 1ns / 1ps
package wprm_pkg;
   localparam int BINS     = 32;
   localparam int CHANNELS = 8;
   localparam int BIN_W    = $clog2(BINS);
   localparam int SWEEP_W  = BIN_W + 3;
   localparam int PK_DEPTH = BINS * 8;
   localparam int FR_W     = 13 + BIN_W;
   localparam int PK_W     = 24 + 58;
   localparam int BN_W     = 13 + 8;

   localparam logic [23:0] UNITY_LEVEL = 24'd1048576;
   localparam logic [57:0] SUM_MAX     = {58{1'b1}};
   localparam logic [12:0] FRAME_MAX   = {13{1'b1}};

   localparam logic [1:0] CSR_ACTIVE_CHANNELS = 2'd0;
   localparam logic [1:0] CSR_FRAMES_PER_BIN  = 2'd1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [2:0]         channel;
      logic signed [23:0] sample;
   } req_type;

   typedef struct packed {
      logic [2:0]  report_channel;
      logic [23:0] peak_level;
      logic [23:0] rms_level;
      logic [7:0]  clip_mask;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_BIN,
      ST_ADV,
      ST_PKRD,
      ST_UPD,
      ST_RFR,
      ST_RPK,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;
endpackage

// File: rtl/wprm_ram.sv
`timescale 1ns / 1ps
module wprm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/windowed_peak_rms_meter_unit.sv
`timescale 1ns / 1ps
// Sliding-window peak / RMS level meter.
// req_*: samples (cmd 0) in channel order, or a report request (cmd 1).
// rsp_*: one result per active channel after a report, last set on the final one.
// csr_*: active_channels (index 0) and frames_per_bin (index 1); any write to
//   either clears the whole window.
// One request is worked on at a time, req_ready is high only when idle.
// A sample steps through ST_BIN, ST_PKRD and ST_UPD (with ST_ADV before ST_PKRD when it
//   opens a new bin, which clears 8 entries of the peak/square memory one per cycle): each
//   step is one access of the single-port-write bin and peak/square memories.
// A report first sums the frame counts over all bins (ST_RFR), then per channel sweeps
//   the bins (ST_RPK) and runs 64 divider steps and 32 square-root steps before the
//   result is held.
// A stalled rsp_ready simply holds the result and the block.
// After reset, and after a write to either register, a clearing pass over all BINS*8
//   peak/square entries runs with req_ready low.
// A report over an empty window returns nothing.
module windowed_peak_rms_meter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wprm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wprm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_wdata
);
   import wprm_pkg::*;

   state_type state_ff, state_in;
   logic [SWEEP_W-1:0] cnt_ff, cnt_in;
   logic [5:0]         it_ff, it_in;
   logic [BIN_W-1:0]   cur_ff, cur_in;
   logic [3:0]         ac_ff;
   logic [12:0]        fpb_ff;
   logic [2:0]         ch_ff, ch_in;
   logic [23:0]        mag_ff, mag_in;
   logic [47:0]        sq_ff, sq_in;
   logic [12:0]        frames_ff, frames_in;
   logic [7:0]         clip_ff, clip_in;
   logic [FR_W-1:0]    frsum_ff, frsum_in;
   logic [7:0]         clipsum_ff, clipsum_in;
   logic [23:0]        peak_ff, peak_in;
   logic [63:0]        tot_ff, tot_in;
   logic [FR_W-1:0]    rem_ff, rem_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        bit_ff, bit_in;
   rsp_type            rsp_ff, rsp_in;

   logic                     pk_we;
   logic [SWEEP_W-1:0]       pk_waddr, pk_raddr;
   logic [PK_W-1:0]          pk_wdata, pk_rdata;
   logic                     bn_we;
   logic [BIN_W-1:0]         bn_waddr, bn_raddr;
   logic [BN_W-1:0]          bn_wdata, bn_rdata;

   wprm_ram #(.WIDTH(PK_W), .DEPTH(PK_DEPTH)) u_pk_ram (
      .clock(clock), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
      .raddr(pk_raddr), .rdata(pk_rdata)
   );

   wprm_ram #(.WIDTH(BN_W), .DEPTH(BINS)) u_bin_ram (
      .clock(clock), .we(bn_we), .waddr(bn_waddr), .wdata(bn_wdata),
      .raddr(bn_raddr), .rdata(bn_rdata)
   );

   // effective configuration
   logic [3:0]  nch;
   logic [12:0] fpb;
   assign nch = (ac_ff == 4'd0) ? 4'd1 :
                ((ac_ff > 4'(CHANNELS)) ? 4'(CHANNELS) : ac_ff);
   assign fpb = (fpb_ff == 13'd0) ? 13'd1 : fpb_ff;

   logic cfg_wr;
   assign cfg_wr = csr_we && (csr_index == CSR_ACTIVE_CHANNELS ||
                              csr_index == CSR_FRAMES_PER_BIN);

   logic             clr_done, sweep_done, ch_active, adv, last_ch;
   logic [FR_W-1:0]  frsum_nx;
   logic [63:0]      tot_nx;
   logic [64:0]      tot_add;
   logic [BIN_W-1:0] cur_nx;
   assign clr_done   = (cnt_ff == SWEEP_W'(PK_DEPTH - 1));
   assign sweep_done = (cnt_ff == SWEEP_W'(BINS));
   assign ch_active  = ({1'b0, req_data.channel} < nch);
   assign adv        = (bn_rdata[BN_W-1:8] >= fpb);
   assign last_ch    = ({1'b0, ch_ff} == nch - 4'd1);
   assign cur_nx     = (cur_ff == BIN_W'(BINS - 1)) ? '0 : cur_ff + 1'b1;
   assign frsum_nx   = frsum_ff + ((cnt_ff != '0) ? FR_W'(bn_rdata[BN_W-1:8]) : '0);
   assign tot_add    = {1'b0, tot_ff} + 65'(pk_rdata[57:0]);
   assign tot_nx     = (cnt_ff == '0) ? tot_ff :
                       (tot_add[64] ? {64{1'b1}} : tot_add[63:0]);

   // divider / root steps
   logic [FR_W:0] rem_sh;
   logic          div_ge;
   logic [63:0]   rb;
   logic          sq_ge;
   assign rem_sh = {rem_ff, tot_ff[63]};
   assign div_ge = (rem_sh >= {1'b0, frsum_ff});
   assign rb     = res_ff + bit_ff;
   assign sq_ge  = (tot_ff >= rb);

   // sample update
   logic [23:0] peak_old;
   logic [58:0] sum_add;
   logic [57:0] sum_new;
   assign peak_old = pk_rdata[PK_W-1:58];
   assign sum_add  = {1'b0, pk_rdata[57:0]} + 59'(sq_ff);
   assign sum_new  = sum_add[58] ? SUM_MAX : sum_add[57:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == CMD_REPORT) state_in = ST_RFR;
               else if (ch_active)              state_in = ST_BIN;
            end
         end
         ST_BIN:  state_in = adv ? ST_ADV : ST_PKRD;
         ST_ADV:  if (cnt_ff[2:0] == 3'd7) state_in = ST_PKRD;
         ST_PKRD: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         ST_RFR: begin
            if (sweep_done) state_in = (frsum_nx == '0) ? ST_IDLE : ST_RPK;
         end
         ST_RPK:  if (sweep_done) state_in = ST_DIV;
         ST_DIV:  if (it_ff == 6'd63) state_in = ST_SQRT;
         ST_SQRT: if (it_ff == 6'd31) state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) state_in = last_ch ? ST_IDLE : ST_RPK;
         end
         default: state_in = ST_CLR;
      endcase
      if (cfg_wr) state_in = ST_CLR;
   end

   always_comb begin
      cnt_in     = cnt_ff;
      it_in      = it_ff;
      cur_in     = cur_ff;
      ch_in      = ch_ff;
      mag_in     = mag_ff;
      sq_in      = sq_ff;
      frames_in  = frames_ff;
      clip_in    = clip_ff;
      frsum_in   = frsum_ff;
      clipsum_in = clipsum_ff;
      peak_in    = peak_ff;
      tot_in     = tot_ff;
      rem_in     = rem_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      rsp_in     = rsp_ff;
      pk_we      = 1'b0;
      pk_waddr   = '0;
      pk_wdata   = '0;
      pk_raddr   = '0;
      bn_we      = 1'b0;
      bn_waddr   = '0;
      bn_wdata   = '0;
      bn_raddr   = cur_ff;
      case (state_ff)
         ST_CLR: begin
            pk_we    = 1'b1;
            pk_waddr = cnt_ff;
            bn_we    = 1'b1;
            bn_waddr = cnt_ff[SWEEP_W-1:3];
            cur_in   = '0;
            cnt_in   = clr_done ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            ch_in      = req_data.channel;
            mag_in     = req_data.sample[23] ? 24'(-req_data.sample) : req_data.sample;
            cnt_in     = '0;
            frsum_in   = '0;
            clipsum_in = '0;
         end
         ST_BIN: begin
            sq_in = mag_ff * mag_ff;
            if (adv) begin
               cur_in    = cur_nx;
               frames_in = '0;
               clip_in   = '0;
            end else begin
               frames_in = bn_rdata[BN_W-1:8];
               clip_in   = bn_rdata[7:0];
            end
         end
         ST_ADV: begin
            // fresh bin: wipe its eight channel entries
            pk_we    = 1'b1;
            pk_waddr = {cur_ff, cnt_ff[2:0]};
            cnt_in   = cnt_ff + 1'b1;
         end
         ST_PKRD: pk_raddr = {cur_ff, ch_ff};
         ST_UPD: begin
            pk_we    = 1'b1;
            pk_waddr = {cur_ff, ch_ff};
            pk_wdata = {(mag_ff > peak_old) ? mag_ff : peak_old, sum_new};
            bn_we    = 1'b1;
            bn_waddr = cur_ff;
            bn_wdata = {(last_ch && frames_ff != FRAME_MAX) ? frames_ff + 1'b1 : frames_ff,
                        clip_ff | ((mag_ff > UNITY_LEVEL) ? (8'd1 << ch_ff) : 8'd0)};
         end
         ST_RFR: begin
            bn_raddr = cnt_ff[BIN_W-1:0];
            frsum_in = frsum_nx;
            if (cnt_ff != '0) clipsum_in = clipsum_ff | bn_rdata[7:0];
            cnt_in = cnt_ff + 1'b1;
            if (sweep_done) begin
               cnt_in  = '0;
               ch_in   = '0;
               peak_in = '0;
               tot_in  = '0;
            end
         end
         ST_RPK: begin
            pk_raddr = {cnt_ff[BIN_W-1:0], ch_ff};
            tot_in   = tot_nx;
            if (cnt_ff != '0 && peak_old > peak_ff) peak_in = peak_old;
            cnt_in = cnt_ff + 1'b1;
            if (sweep_done) begin
               rem_in = '0;
               it_in  = '0;
            end
         end
         ST_DIV: begin
            // restoring division, quotient shifts in behind the dividend
            rem_in = div_ge ? FR_W'(rem_sh - {1'b0, frsum_ff}) : rem_sh[FR_W-1:0];
            tot_in = {tot_ff[62:0], div_ge};
            it_in  = it_ff + 1'b1;
            if (it_ff == 6'd63) begin
               it_in  = '0;
               res_in = '0;
               bit_in = 64'd1 << 62;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               tot_in = tot_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in  = it_ff + 1'b1;
            if (it_ff == 6'd31) begin
               rsp_in.report_channel = ch_ff;
               rsp_in.peak_level     = peak_ff;
               rsp_in.rms_level      = sq_ge ? 24'((res_ff >> 1) + bit_ff) : 24'(res_ff >> 1);
               rsp_in.clip_mask      = clipsum_ff;
               rsp_in.last           = last_ch;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               ch_in   = ch_ff + 1'b1;
               cnt_in  = '0;
               peak_in = '0;
               tot_in  = '0;
            end
         end
         default: ;
      endcase
      if (cfg_wr) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         ac_ff    <= 4'd2;
         fpb_ff   <= 13'd50;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         if (csr_we && csr_index == CSR_ACTIVE_CHANNELS) ac_ff <= csr_wdata[3:0];
         if (csr_we && csr_index == CSR_FRAMES_PER_BIN)  fpb_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      it_ff      <= it_in;
      ch_ff      <= ch_in;
      mag_ff     <= mag_in;
      sq_ff      <= sq_in;
      frames_ff  <= frames_in;
      clip_ff    <= clip_in;
      frsum_ff   <= frsum_in;
      clipsum_ff <= clipsum_in;
      peak_ff    <= peak_in;
      tot_ff     <= tot_in;
      rem_ff     <= rem_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import wprm_pkg::*;

   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          SETTLE      = 24;
   localparam logic [1:0]  CSR_SPARE   = 2'd2;

   // Tracks the meter's window and the level results it should produce.
   class level_scoreboard;
      int unsigned        chan_reg;
      int unsigned        fpb_reg;
      logic [23:0]        peak_store[BINS][CHANNELS];
      logic [57:0]        square_store[BINS][CHANNELS];
      logic [12:0]        frame_store[BINS];
      logic [7:0]         clip_store[BINS];
      int unsigned        ring_pos;
      rsp_type            levels_due[$];
      int                 errors;
      int                 reports;
      int                 levels_seen;

      function new();
         chan_reg = 2;
         fpb_reg = 50;
         errors = 0;
         reports = 0;
         levels_seen = 0;
         clear_window();
      endfunction

      function void clear_window();
         for (int b = 0; b < BINS; b++) begin
            for (int c = 0; c < CHANNELS; c++) begin
               peak_store[b][c] = '0;
               square_store[b][c] = '0;
            end
            frame_store[b] = '0;
            clip_store[b] = '0;
         end
         ring_pos = 0;
      endfunction

      function int unsigned live_channels();
         if (chan_reg == 0) return 1;
         if (chan_reg > CHANNELS) return CHANNELS;
         return chan_reg;
      endfunction

      function void write_reg(logic [1:0] index, logic [12:0] value);
         if (index == CSR_ACTIVE_CHANNELS) chan_reg = value[3:0];
         else if (index == CSR_FRAMES_PER_BIN) fpb_reg = value;
         else return;
         clear_window();
      endfunction

      function logic [63:0] floor_sqrt(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] probe;
         root = '0;
         probe = 64'd1 << 62;
         while (probe > v) probe = probe >> 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      function void note_request(req_type r);
         int unsigned nch;
         int unsigned fpb;
         int unsigned frames;
         logic [7:0]  clip;
         logic [24:0] mag;
         logic [23:0] raw;
         logic [58:0] s58;
         logic [64:0] s64;
         logic [63:0] total;
         logic [23:0] peak;
         rsp_type     lv;
         nch = live_channels();
         fpb = (fpb_reg == 0) ? 1 : fpb_reg;
         if (r.cmd == CMD_SAMPLE) begin
            if (r.channel >= nch) return;
            if (frame_store[ring_pos] >= fpb) begin
               ring_pos = (ring_pos + 1) % BINS;
               for (int c = 0; c < CHANNELS; c++) begin
                  peak_store[ring_pos][c] = '0;
                  square_store[ring_pos][c] = '0;
               end
               frame_store[ring_pos] = '0;
               clip_store[ring_pos] = '0;
            end
            raw = r.sample;
            mag = raw[23] ? (25'h1000000 - {1'b0, raw}) : {1'b0, raw};
            if (mag[23:0] > peak_store[ring_pos][r.channel])
               peak_store[ring_pos][r.channel] = mag[23:0];
            s58 = {1'b0, square_store[ring_pos][r.channel]} + 59'(mag * mag);
            square_store[ring_pos][r.channel] = s58[58] ? SUM_MAX : s58[57:0];
            if (mag > UNITY_LEVEL) clip_store[ring_pos][r.channel] = 1'b1;
            if (r.channel == nch - 1 && frame_store[ring_pos] != FRAME_MAX)
               frame_store[ring_pos]++;
         end else begin
            frames = 0;
            clip = '0;
            for (int b = 0; b < BINS; b++) begin
               frames += frame_store[b];
               clip |= clip_store[b];
            end
            if (frames == 0) return;
            reports++;
            for (int c = 0; c < nch; c++) begin
               peak = '0;
               total = '0;
               for (int b = 0; b < BINS; b++) begin
                  if (peak_store[b][c] > peak) peak = peak_store[b][c];
                  s64 = {1'b0, total} + 65'(square_store[b][c]);
                  total = s64[64] ? '1 : s64[63:0];
               end
               lv.report_channel = c[2:0];
               lv.peak_level = peak;
               lv.rms_level = 24'(floor_sqrt(total / 64'(frames)));
               lv.clip_mask = clip;
               lv.last = (c == nch - 1);
               levels_due.push_back(lv);
            end
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         levels_seen++;
         if (levels_due.size() == 0) begin
            $error("unexpected level result %p", got);
            errors++;
            return;
         end
         want = levels_due.pop_front();
         if (got.report_channel !== want.report_channel) begin
            $error("report_channel: expected %0d, got %0d", want.report_channel,
                   got.report_channel);
            errors++;
         end
         if (got.peak_level !== want.peak_level) begin
            $error("peak_level: expected %0d, got %0d", want.peak_level, got.peak_level);
            errors++;
         end
         if (got.rms_level !== want.rms_level) begin
            $error("rms_level: expected %0d, got %0d", want.rms_level, got.rms_level);
            errors++;
         end
         if (got.clip_mask !== want.clip_mask) begin
            $error("clip_mask: expected %h, got %h", want.clip_mask, got.clip_mask);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   level_scoreboard meter = new();
   int  cycles = 0;
   int  requests_sent = 0;
   int  settings_tried = 1;
   bit  req_calm = 0;
   bit  rsp_calm = 0;

   windowed_peak_rms_meter_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench NOT OK");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) meter.check_response(rsp_data);
   end

   // result side: random stalls after each accepted result
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            stall = rsp_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic push_request(input req_type r);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      meter.note_request(r);
      requests_sent++;
   endtask

   task automatic send_sample(input int ch, input logic [23:0] value);
      req_type r;
      r.cmd = CMD_SAMPLE;
      r.channel = ch[2:0];
      r.sample = value;
      push_request(r);
   endtask

   task automatic send_report();
      req_type r;
      r.cmd = CMD_REPORT;
      r.channel = 3'($urandom_range(0, 7));
      r.sample = 24'($urandom);
      push_request(r);
   endtask

   // drain, let any sample still in flight finish, then write once idle
   task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
      req_valid <= 1'b0;
      while (meter.levels_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (!req_ready) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      meter.write_reg(index, value);
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 4))
         0: return 24'($urandom);
         1: return 24'(UNITY_LEVEL) + 24'($urandom_range(0, 8)) - 24'd4;
         2: return -(24'(UNITY_LEVEL) + 24'($urandom_range(0, 8)) - 24'd4);
         3: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($urandom_range(0, 4095)) - 24'd2048;
      endcase
   endfunction

   task automatic random_phase(input int count);
      int nch;
      int sent;
      nch = meter.live_channels();
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // stray request: any channel, possibly inactive or out of order
            send_sample($urandom_range(0, 7), pick_sample());
            sent++;
         end else begin
            for (int c = 0; c < nch; c++) send_sample(c, pick_sample());
            sent += nch;
         end
         if ($urandom_range(0, 5) == 0) begin
            send_report();
            sent++;
         end
      end
      send_report();
   endtask

   initial begin
      int ac_set[8]  = '{1, 8, 8, 3, 0, 15, 5, 2};
      int fpb_set[8] = '{1, 4096, 1, 2, 0, 8191, 3, 50};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_ACTIVE_CHANNELS;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty window, extremes, clip threshold, stray channels
      req_calm = 1;
      send_report();
      send_sample(0, 24'h7FFFFF);
      send_sample(1, 24'h800000);
      send_sample(0, 24'd0);
      send_sample(1, 24'(UNITY_LEVEL));
      send_report();
      send_sample(0, 24'(UNITY_LEVEL) + 24'd1);
      send_sample(1, -(24'(UNITY_LEVEL) + 24'd1));
      send_sample(0, 24'hFFFFFF);
      send_sample(1, 24'd1);
      send_sample(5, 24'h123456);
      send_sample(7, 24'h7FFFFF);
      send_sample(1, 24'h400000);
      send_sample(0, 24'hC00000);
      send_report();
      req_calm = 0;
      send_sample(0, 24'h000001);
      send_sample(1, 24'hFFFFFF);
      send_report();

      // a write to a spare index must leave the window alone
      write_reg(CSR_SPARE, 13'h1FFF);
      send_report();

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_ACTIVE_CHANNELS, 13'(ac_set[p]));
         write_reg(CSR_FRAMES_PER_BIN, 13'(fpb_set[p]));
         settings_tried++;
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         random_phase(58);
      end
      req_valid <= 1'b0;

      while (meter.levels_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("%0d requests over %0d channel/bin settings, %0d reports, %0d levels checked",
               requests_sent, settings_tried, meter.reports, meter.levels_seen);
      if (meter.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", meter.errors);
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
